@@ sv/bandwidth_rate_limiter_defines.svh @@
// Assertion macros used by the rate limiter checker.
`ifndef BANDWIDTH_RATE_LIMITER_DEFINES_SVH
`define BANDWIDTH_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/brl_pkg.sv @@
// Types, widths and constants of the bandwidth rate limiter.
`default_nettype none
package brl_pkg;

  localparam int TimeW   = 48;
  localparam int NbytesW = 20;
  localparam int RateW   = 40;
  localparam int BufW    = 24;
  localparam int CntW    = 32;
  localparam int MulXW   = 40;
  localparam int UsecW   = 20;
  localparam int QuoW    = 60;
  localparam int DivCntW = 6;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 40;

  localparam logic [UsecW-1:0] UsecPerSec      = 20'd1000000;
  localparam logic [QuoW-1:0]  ShrinkUs        = 60'd1000000;
  localparam logic [QuoW-1:0]  GrowUs          = 60'd10000;
  localparam logic [BufW-1:0]  DefaultBufBytes = 24'd16384;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic {
    ALGO_WINDOW = 1'b0,
    ALGO_TOKEN  = 1'b1
  } algo_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_ALGO_MODE  = 3'd1,
    CFG_RATE_BPS   = 3'd2,
    CFG_BURST_BITS = 3'd3,
    CFG_BUFFER_LEN = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CALC,
    ST_FIN
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [TimeW-1:0]  now_us;
    logic [NbytesW-1:0] nbytes;
  } in_t;

  typedef struct packed {
    logic [TimeW-1:0] wait_us;
    logic             limited;
  } out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic div_start;
    logic calc;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/brl_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module brl_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [brl_pkg::QuoW-1:0]  dividend_i,
  input  wire logic [brl_pkg::RateW-1:0] divisor_i,
  output logic [brl_pkg::QuoW-1:0]       quotient_o,
  output logic                           done_o
);
  import brl_pkg::*;

  logic [RateW-1:0]   rem_q, rem_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [RateW:0]     trial, diff;
  logic               ge;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    trial = {rem_q, quo_q[QuoW-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      // shift the dividend out at the top, the quotient bit in at the bottom
      rem_d = ge ? diff[RateW-1:0] : trial[RateW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

@@ sv/brl_ctrl.sv @@
// Sequencer of the rate limiter: steps one item through prepare, multiply, divide (when needed), calculate and finish.
`default_nettype none
module brl_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire brl_pkg::dp_stat_t   stat_i,
  output brl_pkg::ctrl_cmd_t       cmd_o
);
  import brl_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_PREP;
      ST_PREP:     state_d = ST_MUL;
      ST_MUL:      state_d = stat_i.need_div ? ST_DIV_GO : ST_CALC;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (stat_i.div_done) state_d = ST_CALC;
      ST_CALC:     state_d = ST_FIN;
      ST_FIN:      if (!stat_i.out_busy) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:     cmd_o.prep = 1'b1;
      ST_MUL:      cmd_o.mul = 1'b1;
      ST_DIV_GO:   cmd_o.div_start = 1'b1;
      ST_DIV_WAIT: cmd_o = '0;
      ST_CALC:     cmd_o.calc = 1'b1;
      // hold the result until the output register is free
      ST_FIN:      cmd_o.fin = !stat_i.out_busy;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/brl_dp.sv @@
// Datapath of the rate limiter: config and limiter state, multiplier, divider, result register.
`default_nettype none
module brl_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [brl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [brl_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire brl_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output brl_pkg::out_t                    out_data_o,
  input  wire brl_pkg::ctrl_cmd_t          cmd_i,
  output brl_pkg::dp_stat_t                stat_o
);
  import brl_pkg::*;

  // configuration
  logic             enable_q;
  algo_e            algo_q;
  logic [RateW-1:0] rate_q;
  logic [RateW-1:0] burst_q;
  logic [BufW-1:0]  buflen_q;

  // limiter state
  logic [CntW-1:0]  wbytes_q, wbytes_d;
  logic [CntW-1:0]  thr_q, thr_d;
  logic [TimeW-1:0] wstart_q, wstart_d;
  logic             wopen_q, wopen_d;
  logic [TimeW-1:0] nfree_q, nfree_d;
  logic [TimeW-1:0] bwin_q, bwin_d;

  // item and scratch
  in_t              item_q;
  logic             bypass_q, bypass_d;
  logic             need_div_q, need_div_d;
  logic             hit_q, hit_d;
  logic [MulXW-1:0] mul_x_q, mul_x_d;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic [QuoW-1:0]  prod_q;
  logic [QuoW-1:0]  wait_q, wait_d;
  logic [TimeW-1:0] base_q, base_d;

  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             out_busy;

  logic [QuoW-1:0]  quo;
  logic             div_done;

  logic [BufW-1:0]  buflen_eff;
  logic [RateW-1:0] burst_eff;
  logic             rate_zero;
  logic [CntW-1:0]  wsum;
  logic [TimeW-1:0] earliest, nf_pulled;
  logic [CntW-1:0]  thr_half, bl_quarter;
  logic [CntW:0]    thr_dbl, bl_x8;
  logic             is_write;

  assign buflen_eff = (buflen_q != '0) ? buflen_q : DefaultBufBytes;
  assign burst_eff  = (burst_q != '0) ? burst_q : (rate_q >> 3);
  assign rate_zero  = (rate_q == '0);
  assign is_write   = (item_q.cmd == CMD_WRITE);
  assign wsum       = wbytes_q + CntW'(item_q.nbytes);
  assign earliest   = (item_q.now_us > bwin_q) ? item_q.now_us - bwin_q : '0;
  assign nf_pulled  = (nfree_q < earliest) ? earliest : nfree_q;
  assign thr_half   = thr_q >> 1;
  assign bl_quarter = CntW'(buflen_eff >> 2);
  assign thr_dbl    = {thr_q, 1'b0};
  assign bl_x8      = {{(CntW - BufW - 2){1'b0}}, buflen_eff, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      algo_q   <= ALGO_WINDOW;
      rate_q   <= '0;
      burst_q  <= '0;
      buflen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:     enable_q <= cfg_wdata_i[0];
        CFG_ALGO_MODE:  algo_q   <= algo_e'(cfg_wdata_i[0]);
        CFG_RATE_BPS:   rate_q   <= cfg_wdata_i[RateW-1:0];
        CFG_BURST_BITS: burst_q  <= cfg_wdata_i[RateW-1:0];
        CFG_BUFFER_LEN: buflen_q <= cfg_wdata_i[BufW-1:0];
        default: ;
      endcase
    end
  end

  // state updates of the prepare and finish steps
  always_comb begin
    wbytes_d   = wbytes_q;
    thr_d      = thr_q;
    wstart_d   = wstart_q;
    wopen_d    = wopen_q;
    nfree_d    = nfree_q;
    bwin_d     = bwin_q;
    bypass_d   = bypass_q;
    need_div_d = need_div_q;
    hit_d      = hit_q;
    mul_x_d    = mul_x_q;
    elapsed_d  = elapsed_q;
    if (cmd_i.prep) begin
      bypass_d   = is_write && (item_q.nbytes == '0 || !enable_q || rate_zero);
      need_div_d = 1'b0;
      hit_d      = 1'b0;
      elapsed_d  = '0;
      mul_x_d    = '0;
      if (!is_write) begin
        wbytes_d   = '0;
        thr_d      = CntW'(buflen_eff);
        wopen_d    = 1'b0;
        nfree_d    = item_q.now_us;
        mul_x_d    = burst_eff;
        need_div_d = !rate_zero;
        if (rate_zero) bwin_d = '0;
      end else if (!bypass_d) begin
        if (algo_q == ALGO_TOKEN) begin
          nfree_d    = nf_pulled;
          mul_x_d    = MulXW'({item_q.nbytes, 3'b000});
          need_div_d = 1'b1;
        end else begin
          if (!wopen_q) begin
            wstart_d = item_q.now_us;
            wopen_d  = 1'b1;
          end
          elapsed_d  = wopen_q ? item_q.now_us - wstart_q : '0;
          wbytes_d   = wsum;
          hit_d      = (wsum >= thr_q);
          need_div_d = hit_d;
          mul_x_d    = MulXW'({wsum, 3'b000});
        end
      end
    end else if (cmd_i.fin) begin
      if (!is_write) begin
        if (!rate_zero) bwin_d = (|quo[QuoW-1:TimeW]) ? '1 : quo[TimeW-1:0];
      end else if (!bypass_q) begin
        if (algo_q == ALGO_TOKEN) begin
          nfree_d = base_q + quo[TimeW-1:0];
        end else if (hit_q) begin
          // halve on a long delay, double on a short one, within bounds
          if (wait_q >= ShrinkUs) begin
            thr_d = (thr_half < bl_quarter) ? bl_quarter : thr_half;
          end else if (wait_q < GrowUs) begin
            thr_d = (thr_dbl > bl_x8) ? bl_x8[CntW-1:0] : thr_dbl[CntW-1:0];
          end
          wbytes_d = '0;
          wstart_d = item_q.now_us + wait_q[TimeW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbytes_q <= '0;
      thr_q    <= CntW'(DefaultBufBytes);
      wstart_q <= '0;
      wopen_q  <= 1'b0;
      nfree_q  <= '0;
      bwin_q   <= '0;
    end else begin
      wbytes_q <= wbytes_d;
      thr_q    <= thr_d;
      wstart_q <= wstart_d;
      wopen_q  <= wopen_d;
      nfree_q  <= nfree_d;
      bwin_q   <= bwin_d;
    end
  end

  // delay and new base before the state is committed
  always_comb begin
    wait_d = wait_q;
    base_d = base_q;
    if (cmd_i.calc) begin
      if (algo_q == ALGO_TOKEN) begin
        wait_d = (nfree_q > item_q.now_us) ? QuoW'(nfree_q - item_q.now_us) : '0;
        base_d = (nfree_q > item_q.now_us) ? nfree_q : item_q.now_us;
      end else begin
        wait_d = (quo > QuoW'(elapsed_q)) ? quo - QuoW'(elapsed_q) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.mul)  prod_q <= QuoW'(mul_x_q) * QuoW'(UsecPerSec);
    bypass_q   <= bypass_d;
    need_div_q <= need_div_d;
    hit_q      <= hit_d;
    mul_x_q    <= mul_x_d;
    elapsed_q  <= elapsed_d;
    wait_q     <= wait_d;
    base_q     <= base_d;
  end

  brl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (rate_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // result register: a finished beat waits here while the next item is taken
  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    out_valid_d = cmd_i.fin || out_busy;
    out_d       = out_q;
    if (cmd_i.fin) begin
      out_d.limited = is_write && !bypass_q;
      if (is_write && !bypass_q && (algo_q == ALGO_TOKEN || hit_q)) begin
        out_d.wait_us = (|wait_q[QuoW-1:TimeW]) ? '1 : wait_q[TimeW-1:0];
      end else begin
        out_d.wait_us = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.need_div = need_div_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_busy;

endmodule
`default_nettype wire

@@ sv/bandwidth_rate_limiter.sv @@
// Top level of the bandwidth rate limiter (token bucket / adaptive window).
//
//   port group  | handshake              | beat payload
//   ------------+------------------------+-------------------------------
//   item in     | in_valid_i/in_ready_o  | in_data_i  (cmd, now_us, nbytes)
//   result out  | out_valid_o/out_ready_i| out_data_o (wait_us, limited)
//   config      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// An item that divides (start with nonzero rate, token write, window close)
// also runs the 60-step radix-2 divider between the multiply and calculate
// steps; other items go straight from multiply to calculate.
// One item is in flight at a time; the next is taken while a result beat waits.
// Reset is asynchronous, active low; no clearing pass is needed after it.
`default_nettype none
module bandwidth_rate_limiter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [brl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [brl_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire brl_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output brl_pkg::out_t                    out_data_o
);
  import brl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  brl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

@@ sv/brl_checker.sv @@
// Port-level checks of the rate limiter, bound to the top level.
`include "bandwidth_rate_limiter_defines.svh"
`default_nettype none
module brl_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire brl_pkg::out_t out_data_o
);
  import brl_pkg::*;

  // one item at a time: an accepted beat closes the input
  `BRL_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
    "input taken while an item is in flight")

  // a result appears only at the end of an item's work
  `BRL_ASSERT_NOW(a_result_after_work, $rose(out_valid_o), !$past(in_ready_o),
    "result beat without an item in flight")

  // a bypassed item never asks for a delay
  `BRL_ASSERT_NOW(a_bypass_no_wait, out_valid_o && !out_data_o.limited,
    out_data_o.wait_us == '0, "delay on an item that was not accounted")

  `BRL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "stalled result beat changed")

endmodule

bind bandwidth_rate_limiter brl_checker u_brl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
